// File: hdl/tcw_pkg.sv
// tcw_pkg: shared constants, command codes and address helper for the text console writer
`timescale 1ns / 1ps

package tcw_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // field widths
  localparam int CMD_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int ROW_W   = 5;
  localparam int TROW_W  = 6;
  localparam int COL_W   = 7;
  localparam int CELL_W  = 16;
  localparam int POS_W   = 11;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUT_CURSOR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUT_CELL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ       = 2'd3;

  // character codes
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;

  // fixed addresses and limits
  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] BOTTOM_ADDR = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP    = ADDR_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);
  localparam logic [TROW_W-1:0] ROW_LIMIT   = TROW_W'(ROWS);
  localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(COLUMNS - 1);
  localparam logic [COL_W-1:0]  COL_LIMIT   = COL_W'(COLUMNS);

  // linear cell address of a row and column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [TROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ROW_STEP + ADDR_W'(col);
  endfunction

endpackage

// File: hdl/tcw_if.sv
// tcw_if: command and response channel interfaces of the text console writer
`timescale 1ns / 1ps

interface tcw_cmd_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] char_code;
  logic [BYTE_W-1:0] color;
  logic [TROW_W-1:0] target_row;
  logic [COL_W-1:0]  target_col;

  modport source(output valid, command, char_code, color, target_row, target_col,
                 input ready);
  modport sink(input valid, command, char_code, color, target_row, target_col,
               output ready);
endinterface

interface tcw_rsp_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  cursor_row_out;
  logic [COL_W-1:0]  cursor_col_out;
  logic [POS_W-1:0]  cursor_position;
  logic [CELL_W-1:0] cell_entry;
  logic              scrolled;
  logic              ignored;

  modport source(output valid, cursor_row_out, cursor_col_out, cursor_position,
                 cell_entry, scrolled, ignored, input ready);
  modport sink(input valid, cursor_row_out, cursor_col_out, cursor_position,
               cell_entry, scrolled, ignored, output ready);
endinterface

// File: hdl/text_console_writer_core.sv
// text_console_writer_core: text terminal engine over a one-port-read, one-port-write screen memory
//
//   channel  direction  beat contents
//   -------  ---------  ------------------------------------------------------------
//   cmd      in         command, char_code, color, target_row, target_col
//   rsp      out        cursor row/col, cursor_position, cell_entry, scrolled, ignored
//
// an ordinary command issues its cell write or read in the accept cycle, and the beat is
// loaded into the response register in ST_FINISH once that register is free or being taken
// a scroll copies the screen up a row through the memory, one cell a cycle, then passes
// through ST_DRAIN for the last copy write and blanks the bottom row
// a clear writes CELL_COUNT cells, one a cycle
// reset clears only the cursor and control state; cells are undefined until written
// a new command is taken once the previous beat sits in the response register
`timescale 1ns / 1ps

module text_console_writer_core
  import tcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tcw_cmd_if.sink    cmd,
  tcw_rsp_if.source  rsp
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FINISH = 3'd1;
  localparam logic [2:0] ST_SCROLL = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FILL   = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] copy_addr;
  logic              copy_valid;
  logic [BYTE_W-1:0] color_r;
  logic              res_scrolled;
  logic              res_ignored;
  logic              res_read;

  // screen memory
  logic [CELL_W-1:0] screen_mem [CELL_COUNT];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // command decode
  logic              accept;
  logic              target_ok;
  logic [ADDR_W-1:0] target_addr;
  logic [TROW_W-1:0] row_inc;
  logic [TROW_W-1:0] put_row;
  logic [COL_W-1:0]  put_col;
  logic              put_we;
  logic [ADDR_W-1:0] put_addr;
  logic [BYTE_W-1:0] wr_char;
  logic              put_scroll;
  logic              load_rsp;

  assign accept      = cmd.valid && cmd.ready;
  assign cmd.ready   = (state == ST_IDLE);
  assign target_ok   = (cmd.target_row < ROW_LIMIT) && (cmd.target_col < COL_LIMIT);
  assign target_addr = cell_addr(cmd.target_row, cmd.target_col);
  assign row_inc     = {1'b0, cur_row} + TROW_W'(1);

  // cursor motion for put at cursor
  always_comb begin
    put_row  = {1'b0, cur_row};
    put_col  = cur_col;
    put_we   = 1'b0;
    put_addr = cell_addr({1'b0, cur_row}, cur_col);
    wr_char  = cmd.char_code;
    if (cmd.char_code == CH_NEWLINE) begin
      put_row = row_inc;
      put_col = '0;
    end else if (cmd.char_code == CH_BACKSPACE) begin
      wr_char = CH_SPACE;
      if (cur_col != '0) begin
        put_col  = cur_col - COL_W'(1);
        put_we   = 1'b1;
        put_addr = cell_addr({1'b0, cur_row}, put_col);
      end else if (cur_row != '0) begin
        put_row  = {1'b0, cur_row} - TROW_W'(1);
        put_col  = COL_LAST;
        put_we   = 1'b1;
        put_addr = cell_addr(put_row, put_col);
      end
    end else begin
      put_we = 1'b1;
      if (cur_col == COL_LAST) begin
        put_col = '0;
        put_row = row_inc;
      end else begin
        put_col = cur_col + COL_W'(1);
      end
    end
    put_scroll = (put_row == ROW_LIMIT);
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = put_addr;
    mem_wdata = {cmd.color, wr_char};
    mem_re    = 1'b0;
    mem_raddr = target_addr;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd.command)
            CMD_PUT_CURSOR: mem_we = put_we;
            CMD_PUT_CELL: begin
              mem_we    = target_ok;
              mem_waddr = target_addr;
              mem_wdata = {cmd.color, cmd.char_code};
            end
            CMD_READ: mem_re = target_ok;
            default: ;
          endcase
        end
      end
      ST_SCROLL: begin
        mem_re    = 1'b1;
        mem_raddr = ptr;
        mem_we    = copy_valid;
        mem_waddr = copy_addr;
        mem_wdata = mem_rdata;
      end
      ST_DRAIN: begin
        mem_we    = 1'b1;
        mem_waddr = copy_addr;
        mem_wdata = mem_rdata;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = {color_r, CH_SPACE};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= screen_mem[mem_raddr];
    end
  end

  // sequencer
  assign load_rsp = (state == ST_FINISH) && (!rsp.valid || rsp.ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd.command == CMD_CLEAR) begin
            state_next = ST_FILL;
          end else if (cmd.command == CMD_PUT_CURSOR && put_scroll) begin
            state_next = ST_SCROLL;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_SCROLL: if (ptr == LAST_ADDR) state_next = ST_DRAIN;
      ST_DRAIN:  state_next = ST_FILL;
      ST_FILL:   if (ptr == LAST_ADDR) state_next = ST_FINISH;
      ST_FINISH: if (load_rsp) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur_row    <= '0;
      cur_col    <= '0;
      copy_valid <= 1'b0;
    end else begin
      state      <= state_next;
      copy_valid <= (state == ST_SCROLL);
      if (accept) begin
        if (cmd.command == CMD_CLEAR) begin
          cur_row <= '0;
          cur_col <= '0;
        end else if (cmd.command == CMD_PUT_CURSOR) begin
          if (put_scroll) begin
            cur_row <= ROW_LAST;
            cur_col <= '0;
          end else begin
            cur_row <= put_row[ROW_W-1:0];
            cur_col <= put_col;
          end
        end
      end
    end
  end

  // per-command working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      color_r      <= cmd.color;
      res_scrolled <= (cmd.command == CMD_PUT_CURSOR) && put_scroll;
      res_ignored  <= (cmd.command inside {CMD_PUT_CELL, CMD_READ}) && !target_ok;
      res_read     <= (cmd.command == CMD_READ) && target_ok;
      if (cmd.command == CMD_CLEAR) begin
        ptr <= '0;
      end else begin
        ptr <= ROW_STEP;
      end
    end else if (state == ST_SCROLL) begin
      copy_addr <= ptr - ROW_STEP;
      ptr       <= ptr + ADDR_W'(1);
    end else if (state == ST_DRAIN) begin
      ptr <= BOTTOM_ADDR;
    end else if (state == ST_FILL) begin
      ptr <= ptr + ADDR_W'(1);
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.cursor_row_out  <= cur_row;
      rsp.cursor_col_out  <= cur_col;
      rsp.cursor_position <= POS_W'(cell_addr({1'b0, cur_row}, cur_col));
      rsp.cell_entry      <= res_read ? mem_rdata : '0;
      rsp.scrolled        <= res_scrolled;
      rsp.ignored         <= res_ignored;
    end
  end

  // checks
  a_row_range: assert property (@(posedge clk) disable iff (rst) cur_row <= ROW_LAST)
    else $error("cursor row beyond last row");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (mem_waddr <= LAST_ADDR))
    else $error("screen write outside the store");

  a_scroll_home: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.scrolled) |-> (rsp.cursor_row_out == ROW_LAST && rsp.cursor_col_out == '0))
    else $error("scroll beat without cursor at bottom row start");

  a_ignored_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ignored) |-> (rsp.cell_entry == '0 && !rsp.scrolled))
    else $error("ignored beat carries data");

endmodule

// File: tb/sv/tb.sv
// tb: self-checking testbench for the text console writer core
`timescale 1ns / 1ps

module tb;
  import tcw_pkg::*;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] char_code;
    logic [BYTE_W-1:0] color;
    logic [TROW_W-1:0] target_row;
    logic [COL_W-1:0]  target_col;
  } console_cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_out;
    logic [COL_W-1:0]  col_out;
    logic [POS_W-1:0]  position;
    logic [CELL_W-1:0] entry;
    logic              scrolled;
    logic              ignored;
  } cursor_report_t;

  logic clk;
  logic rst;

  tcw_cmd_if cmd_bus ();
  tcw_rsp_if rsp_bus ();

  text_console_writer_core uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .rsp (rsp_bus)
  );

  // shadow screen and cursor
  logic [CELL_W-1:0] screen_shadow [CELL_COUNT];
  logic [ROW_W-1:0]  shadow_row;
  logic [COL_W-1:0]  shadow_col;

  cursor_report_t expected_reports [$];
  int mismatch_count;
  int send_idle_pct;
  int recv_stall_pct;

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hang guard: far beyond a run made entirely of clears under full stalls
  initial begin
    #(64'd200_000_000);
    $display("tb: errors");
    $finish;
  end

  // apply one command to the shadow screen and return the cursor report it yields
  function automatic cursor_report_t apply_console_cmd(console_cmd_t c);
    cursor_report_t r;
    int row;
    int col;
    logic [ADDR_W-1:0] i;
    bit in_range;
    bit moved;
    r = '0;
    row = int'(shadow_row);
    col = int'(shadow_col);
    in_range = (c.target_row < ROW_LIMIT) && (c.target_col < COL_LIMIT);
    case (c.command)
      CMD_PUT_CURSOR: begin
        if (c.char_code == CH_NEWLINE) begin
          col = 0;
          row++;
        end else if (c.char_code == CH_BACKSPACE) begin
          moved = 1'b1;
          if (col != 0) begin
            col--;
          end else if (row != 0) begin
            row--;
            col = COLUMNS - 1;
          end else begin
            moved = 1'b0;
          end
          if (moved)
            screen_shadow[cell_addr(TROW_W'(row), COL_W'(col))] = {c.color, CH_SPACE};
        end else begin
          screen_shadow[cell_addr(TROW_W'(row), COL_W'(col))] = {c.color, c.char_code};
          col++;
          if (col >= COLUMNS) begin
            col = 0;
            row++;
          end
        end
        // past the bottom: shift everything up a row and blank the last one
        if (row >= ROWS) begin
          for (i = '0; i < BOTTOM_ADDR; i++)
            screen_shadow[i] = screen_shadow[i + ROW_STEP];
          for (i = BOTTOM_ADDR; i <= LAST_ADDR; i++)
            screen_shadow[i] = {c.color, CH_SPACE};
          row = ROWS - 1;
          col = 0;
          r.scrolled = 1'b1;
        end
      end
      CMD_PUT_CELL: begin
        if (in_range)
          screen_shadow[cell_addr(c.target_row, c.target_col)] = {c.color, c.char_code};
        else
          r.ignored = 1'b1;
      end
      CMD_CLEAR: begin
        for (i = '0; i <= LAST_ADDR; i++) screen_shadow[i] = {c.color, CH_SPACE};
        row = 0;
        col = 0;
      end
      CMD_READ: begin
        if (in_range)
          r.entry = screen_shadow[cell_addr(c.target_row, c.target_col)];
        else
          r.ignored = 1'b1;
      end
      default: ;
    endcase
    shadow_row = ROW_W'(row);
    shadow_col = COL_W'(col);
    r.row_out = ROW_W'(row);
    r.col_out = COL_W'(col);
    r.position = POS_W'(row * COLUMNS + col);
    return r;
  endfunction

  function automatic console_cmd_t make_cmd(logic [CMD_W-1:0] command,
                                            logic [BYTE_W-1:0] char_code,
                                            logic [BYTE_W-1:0] color,
                                            logic [TROW_W-1:0] target_row,
                                            logic [COL_W-1:0] target_col);
    console_cmd_t c;
    c.command = command;
    c.char_code = char_code;
    c.color = color;
    c.target_row = target_row;
    c.target_col = target_col;
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // drive one command beat and record its expected report once accepted
  task automatic send_console_cmd(console_cmd_t c);
    cmd_bus.command    <= c.command;
    cmd_bus.char_code  <= c.char_code;
    cmd_bus.color      <= c.color;
    cmd_bus.target_row <= c.target_row;
    cmd_bus.target_col <= c.target_col;
    cmd_bus.valid      <= 1'b1;
    do @(posedge clk); while (!cmd_bus.ready);
    expected_reports.push_back(apply_console_cmd(c));
    // optional idle gap after the beat
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // hold off the sender until every report is back
  task automatic wait_reports_drained();
    cmd_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // compare each report beat with the oldest expectation
  always @(posedge clk) begin : report_check
    cursor_report_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("report beat with nothing expected");
      end else begin
        want = expected_reports.pop_front();
        check_field("cursor_row_out", 32'(rsp_bus.cursor_row_out), 32'(want.row_out));
        check_field("cursor_col_out", 32'(rsp_bus.cursor_col_out), 32'(want.col_out));
        check_field("cursor_position", 32'(rsp_bus.cursor_position), 32'(want.position));
        check_field("cell_entry", 32'(rsp_bus.cell_entry), 32'(want.entry));
        check_field("scrolled", 32'(rsp_bus.scrolled), 32'(want.scrolled));
        check_field("ignored", 32'(rsp_bus.ignored), 32'(want.ignored));
      end
    end
  end

  // edges of every field, backspace and wrap cases, out-of-range targets
  task automatic test_directed();
    send_console_cmd(make_cmd(CMD_PUT_CELL, 8'h41, 8'h00, 0, 0));
    send_console_cmd(make_cmd(CMD_PUT_CURSOR, CH_BACKSPACE, 8'h33, 0, 0));
    send_console_cmd(make_cmd(CMD_CLEAR, 8'h00, 8'h00, 0, 0));
    send_console_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, 0, 0));
    send_console_cmd(make_cmd(CMD_PUT_CURSOR, 8'hFF, 8'hFF, 0, 0));
    send_console_cmd(make_cmd(CMD_PUT_CURSOR, 8'h00, 8'h00, 0, 0));
    send_console_cmd(make_cmd(CMD_PUT_CURSOR, CH_BACKSPACE, 8'h5A, 0, 0));
    send_console_cmd(make_cmd(CMD_PUT_CURSOR, CH_NEWLINE, 8'h00, 0, 0));
    // backspace at column 0 goes to the end of the row above
    send_console_cmd(make_cmd(CMD_PUT_CURSOR, CH_BACKSPACE, 8'hC3, 0, 0));
    // a character at the last column wraps to the next row
    send_console_cmd(make_cmd(CMD_PUT_CURSOR, 8'h41, 8'hA5, 0, 0));
    send_console_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, 0, COL_LAST));
    send_console_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, 0, 1));
    send_console_cmd(make_cmd(CMD_PUT_CELL, 8'h7E, 8'hF0, TROW_W'(ROW_LAST), COL_LAST));
    send_console_cmd(make_cmd(CMD_READ, 8'hFF, 8'hFF, TROW_W'(ROW_LAST), COL_LAST));
    send_console_cmd(make_cmd(CMD_PUT_CELL, 8'h55, 8'h0F, ROW_LIMIT, 0));
    send_console_cmd(make_cmd(CMD_PUT_CELL, 8'h55, 8'h0F, 0, COL_LIMIT));
    send_console_cmd(make_cmd(CMD_PUT_CELL, 8'hAA, 8'hFF, 6'd63, 7'd127));
    send_console_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, 6'd63, 7'd127));
    send_console_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, ROW_LIMIT, COL_LAST));
    send_console_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, TROW_W'(ROW_LAST), 0));
    send_console_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, 1, 1));
  endtask

  // newlines down to the bottom row, then scroll and look at the moved rows
  task automatic test_scroll();
    send_console_cmd(make_cmd(CMD_CLEAR, 8'h00, 8'h1F, 0, 0));
    send_console_cmd(make_cmd(CMD_PUT_CURSOR, 8'h58, 8'h2E, 0, 0));
    repeat (ROWS - 1) send_console_cmd(make_cmd(CMD_PUT_CURSOR, CH_NEWLINE, 8'h47, 0, 0));
    send_console_cmd(make_cmd(CMD_PUT_CURSOR, 8'h59, 8'h61, 0, 0));
    send_console_cmd(make_cmd(CMD_PUT_CURSOR, CH_NEWLINE, 8'h9C, 0, 0));
    send_console_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, TROW_W'(ROW_LAST - 1), 0));
    send_console_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, TROW_W'(ROW_LAST), 5));
    send_console_cmd(make_cmd(CMD_READ, 8'h00, 8'h00, 0, 0));
    send_console_cmd(make_cmd(CMD_PUT_CURSOR, CH_BACKSPACE, 8'h12, 0, 0));
    send_console_cmd(make_cmd(CMD_PUT_CURSOR, 8'h5A, 8'h34, 0, 0));
  endtask

  // bursts of text, cell writes, reads and noise, with a rare clear
  task automatic run_console_traffic(int item_total);
    console_cmd_t c;
    int sent;
    int burst;
    int kind;
    int pick;
    sent = 0;
    while (sent < item_total) begin
      kind = $urandom_range(0, 99);
      burst = (kind >= 97) ? 1 : $urandom_range(1, 40);
      while (burst > 0 && sent < item_total) begin
        c.command    = CMD_W'($urandom_range(0, 3));
        c.char_code  = BYTE_W'($urandom_range(0, 255));
        c.color      = BYTE_W'($urandom_range(0, 255));
        c.target_row = TROW_W'($urandom_range(0, 63));
        c.target_col = COL_W'($urandom_range(0, 127));
        // mostly in-range targets
        if ($urandom_range(0, 99) < 85) begin
          c.target_row = TROW_W'($urandom_range(0, ROWS - 1));
          c.target_col = COL_W'($urandom_range(0, COLUMNS - 1));
        end
        if (kind < 55) begin
          c.command = CMD_PUT_CURSOR;
          pick = $urandom_range(0, 99);
          if (pick < 8) c.char_code = CH_NEWLINE;
          else if (pick < 14) c.char_code = CH_BACKSPACE;
        end else if (kind < 70) begin
          c.command = CMD_PUT_CELL;
        end else if (kind < 85) begin
          c.command = CMD_READ;
        end else if (kind >= 97) begin
          c.command = CMD_CLEAR;
        end
        send_console_cmd(c);
        sent++;
        burst--;
      end
    end
  endtask

  task automatic test_random_traffic();
    // no idling
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_console_traffic(225);
    wait_reports_drained();
    // sender idle
    send_idle_pct = 49;
    recv_stall_pct = 0;
    run_console_traffic(225);
    wait_reports_drained();
    // receiver stalling
    send_idle_pct = 0;
    recv_stall_pct = 49;
    run_console_traffic(225);
    wait_reports_drained();
    // both sides
    send_idle_pct = 37;
    recv_stall_pct = 37;
    run_console_traffic(225);
  endtask

  initial begin
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    shadow_row = '0;
    shadow_col = '0;
    rst <= 1'b1;
    cmd_bus.valid      <= 1'b0;
    cmd_bus.command    <= CMD_PUT_CURSOR;
    cmd_bus.char_code  <= '0;
    cmd_bus.color      <= '0;
    cmd_bus.target_row <= '0;
    cmd_bus.target_col <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_scroll();
    wait_reports_drained();
    test_random_traffic();
    wait_reports_drained();
    repeat (100) @(posedge clk);

    if (mismatch_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

// File: sim.f
hdl/tcw_pkg.sv
hdl/tcw_if.sv
hdl/text_console_writer_core.sv
tb/sv/tb.sv
